>>> rtl/barometric_sensor_compensation_core_defines.svh
// assertion macros for the barometric compensation core checker
// expects signals named clk and arst_n in the scope of use
`ifndef BAROMETRIC_SENSOR_COMPENSATION_CORE_DEFINES_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BSC_AST_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bsc: same-cycle check failed");

// next-cycle implication, disabled in reset
`define BSC_AST_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bsc: next-cycle check failed");

`endif

>>> rtl/bsc_pkg.sv
// shared constants, types and arithmetic helpers for the compensation core
// no dependencies
`timescale 1ns / 1ps

package bsc_pkg;

	localparam int ADC_W       = 20;
	localparam int REG_W       = 48;
	localparam int APB_ADDR_W  = 5;
	localparam int APB_DATA_W  = 64;
	localparam int DIV_STAGES  = 64;
	localparam int DIVISOR_W   = 31;

	localparam logic [63:0] TEMP_OFS   = 64'd128000;
	localparam logic [63:0] PRES_SCALE = 64'd3125;
	localparam logic [63:0] PRES_BIAS  = 64'h0000_8000_0000_0000;
	localparam logic [63:0] PRES_FULL  = 64'h0000_0000_0010_0000;

	// register index, taken from paddr[4:3]
	typedef enum logic [1:0] {
		CFG_TEMP   = 2'd0,
		CFG_PRES_A = 2'd1,
		CFG_PRES_B = 2'd2,
		CFG_PRES_C = 2'd3
	} cfg_idx_t;

	// partial products of a 64x64 multiply, low 64 bits only
	typedef struct packed {
		logic [63:0] lo;
		logic [31:0] mid;
	} pp_t;

	// side data riding along the divider
	typedef struct packed {
		logic [31:0] temp;
		logic        neg;
		logic        zero;
	} div_side_t;

	function automatic logic [63:0] sx16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	// first half of a wrapping 64-bit multiply: three 32x32 products
	function automatic pp_t mul_pp(input logic [63:0] a, input logic [63:0] b);
		pp_t r;
		r.lo  = 64'(a[31:0]) * 64'(b[31:0]);
		r.mid = (a[31:0] * b[63:32]) + (a[63:32] * b[31:0]);
		return r;
	endfunction

	// second half: fold the cross terms in
	function automatic logic [63:0] mul_sum(input pp_t p);
		return p.lo + {p.mid, 32'h0};
	endfunction

endpackage

>>> rtl/bsc_ifs.sv
// valid/ready channels of the compensation core: raw readings in, results out
// depends on bsc_pkg
`timescale 1ns / 1ps

interface bsc_raw_if;
	import bsc_pkg::*;
	logic             valid;
	logic             ready;
	logic [ADC_W-1:0] adc_temperature;
	logic [ADC_W-1:0] adc_pressure;
	modport source(output valid, adc_temperature, adc_pressure, input ready);
	modport sink(input valid, adc_temperature, adc_pressure, output ready);
endinterface

interface bsc_comp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] temperature_centi;
	logic [31:0]        pressure_q24_8;
	logic               divisor_zero;
	modport source(output valid, temperature_centi, pressure_q24_8, divisor_zero,
		input ready);
	modport sink(input valid, temperature_centi, pressure_q24_8, divisor_zero,
		output ready);
endinterface

>>> rtl/barometric_sensor_compensation_core.sv
// top level of the barometric temperature/pressure compensation core
// depends on bsc_pkg, bsc_ifs and bsc_div
`timescale 1ns / 1ps

// Usage
//   raw  : sink channel, one word = raw 20-bit temperature and pressure reading
//   comp : source channel, one word = temperature (0.01 degC), pressure (Q24.8 Pa)
//          and a flag set when the pressure divisor is zero (pressure then 0)
//   apb  : four 48-bit calibration registers at byte addresses 0, 8, 16, 24,
//          64-bit data; write them only while no reading is in flight
// Pipeline from acceptance of a reading to its result on comp:
//   13 stages of temperature and pressure pre-terms, 64 divider stages
//   (one quotient bit each), 7 stages of pressure post-terms and output.
// Throughput: one reading per cycle while comp is not stalled.
// Stalls: the whole pipeline advances when the output register is empty or
//   taken; while comp is stalled with a word waiting, raw.ready is low and
//   nothing inside moves.
// Reset: clears all stage valid bits and the calibration registers.

module barometric_sensor_compensation_core (
	input  logic                           clk,
	input  logic                           arst_n,
	bsc_raw_if.sink                        raw,
	bsc_comp_if.source                     comp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bsc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [bsc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [bsc_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import bsc_pkg::*;

	// calibration registers
	logic [REG_W-1:0] temp_coeffs_q, pres_a_q, pres_b_q, pres_c_q;
	cfg_idx_t         cfg_idx;
	logic             cfg_wr;

	assign cfg_idx = cfg_idx_t'(paddr[4:3]);
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q <= '0;
			pres_a_q      <= '0;
			pres_b_q      <= '0;
			pres_c_q      <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				CFG_TEMP:   temp_coeffs_q <= pwdata[REG_W-1:0];
				CFG_PRES_A: pres_a_q      <= pwdata[REG_W-1:0];
				CFG_PRES_B: pres_b_q      <= pwdata[REG_W-1:0];
				CFG_PRES_C: pres_c_q      <= pwdata[REG_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			CFG_TEMP:   prdata = 64'(temp_coeffs_q);
			CFG_PRES_A: prdata = 64'(pres_a_q);
			CFG_PRES_B: prdata = 64'(pres_b_q);
			CFG_PRES_C: prdata = 64'(pres_c_q);
			default:    prdata = '0;
		endcase
	end

	// coefficient fields
	logic [31:0] t1_32, t2_32, t3_32;
	logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

	assign t1_32 = 32'(temp_coeffs_q[15:0]);
	assign t2_32 = {{16{temp_coeffs_q[31]}}, temp_coeffs_q[31:16]};
	assign t3_32 = {{16{temp_coeffs_q[47]}}, temp_coeffs_q[47:32]};
	assign p1    = 64'(pres_a_q[15:0]);
	assign p2    = sx16(pres_a_q[31:16]);
	assign p3    = sx16(pres_a_q[47:32]);
	assign p4    = sx16(pres_b_q[15:0]);
	assign p5    = sx16(pres_b_q[31:16]);
	assign p6    = sx16(pres_b_q[47:32]);
	assign p7    = sx16(pres_c_q[15:0]);
	assign p8    = sx16(pres_c_q[31:16]);
	assign p9    = sx16(pres_c_q[47:32]);

	// pipeline advance
	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic vld_s10, vld_s11, vld_s12, vld_s13, vld_s14, vld_s15, vld_s16, vld_s17;
	logic vld_s18, vld_s19, vld_s20;
	logic div_vld;

	assign adv       = !vld_s20 || comp.ready;
	assign raw.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7} <= '0;
			{vld_s8, vld_s9, vld_s10, vld_s11, vld_s12, vld_s13}     <= '0;
			{vld_s14, vld_s15, vld_s16, vld_s17, vld_s18, vld_s19}   <= '0;
			vld_s20 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= raw.valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= div_vld;
			vld_s15 <= vld_s14;
			vld_s16 <= vld_s15;
			vld_s17 <= vld_s16;
			vld_s18 <= vld_s17;
			vld_s19 <= vld_s18;
			vld_s20 <= vld_s19;
		end
	end

	// temperature terms, 32-bit wrapping
	logic [31:0] ta, td;

	assign ta = 32'(raw.adc_temperature[ADC_W-1:3]) - {t1_32[30:0], 1'b0};
	assign td = 32'(raw.adc_temperature[ADC_W-1:4]) - t1_32;

	logic [31:0] v1raw_s1, dd_s1, v1_s2, m_s2, fine_s3;
	logic [31:0] fine5;
	logic [ADC_W-1:0] adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5, adcp_s6;
	logic [ADC_W-1:0] adcp_s7, adcp_s8;
	logic [31:0] temp_s4, temp_s5, temp_s6, temp_s7, temp_s8, temp_s9;
	logic [31:0] temp_s10, temp_s11, temp_s12;
	logic [63:0] w1_s4, a_s6, c_s6, e_s6, c_s7, e_s7, c_s8, e_s8;
	logic [63:0] b_s8, d_s8, w2_s9, w1b_s9, p0_s9, nin_s10, f_s11, n_s12;
	logic [63:0] nmag_s13;
	logic [63:0] dvfull;
	logic [DIVISOR_W-1:0] dv_s12, dmag_s13;
	pp_t ppa_s5, ppc_s5, ppe_s5, ppb_s7, ppd_s7, ppf_s10, ppn_s11;
	div_side_t side_s13;

	assign fine5  = {fine_s3[29:0], 2'b00} + fine_s3;
	assign dvfull = $signed(f_s11) >>> 33;

	// pre-divider stages
	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: first temperature products
			v1raw_s1 <= ta * t2_32;
			dd_s1    <= td * td;
			adcp_s1  <= raw.adc_pressure;
			// s2: scale terms
			v1_s2    <= 32'($signed(v1raw_s1) >>> 11);
			m_s2     <= 32'($signed(dd_s1) >>> 12) * t3_32;
			adcp_s2  <= adcp_s1;
			// s3: fine temperature
			fine_s3  <= v1_s2 + 32'($signed(m_s2) >>> 14);
			adcp_s3  <= adcp_s2;
			// s4: temperature result and pressure offset term
			temp_s4  <= 32'($signed(fine5 + 32'd128) >>> 8);
			w1_s4    <= {{32{fine_s3[31]}}, fine_s3} - TEMP_OFS;
			adcp_s4  <= adcp_s3;
			// s5: partial products of w1*w1, w1*p5, w1*p2
			ppa_s5   <= mul_pp(w1_s4, w1_s4);
			ppc_s5   <= mul_pp(w1_s4, p5);
			ppe_s5   <= mul_pp(w1_s4, p2);
			temp_s5  <= temp_s4;
			adcp_s5  <= adcp_s4;
			// s6
			a_s6     <= mul_sum(ppa_s5);
			c_s6     <= mul_sum(ppc_s5);
			e_s6     <= mul_sum(ppe_s5);
			temp_s6  <= temp_s5;
			adcp_s6  <= adcp_s5;
			// s7: square times p6 and p3
			ppb_s7   <= mul_pp(a_s6, p6);
			ppd_s7   <= mul_pp(a_s6, p3);
			c_s7     <= c_s6;
			e_s7     <= e_s6;
			temp_s7  <= temp_s6;
			adcp_s7  <= adcp_s6;
			// s8
			b_s8     <= mul_sum(ppb_s7);
			d_s8     <= mul_sum(ppd_s7);
			c_s8     <= c_s7;
			e_s8     <= e_s7;
			temp_s8  <= temp_s7;
			adcp_s8  <= adcp_s7;
			// s9: combine into w2 and the divisor pre-term
			w2_s9    <= b_s8 + {c_s8[46:0], 17'h0} + {p4[28:0], 35'h0};
			w1b_s9   <= 64'($signed(d_s8) >>> 8) + {e_s8[51:0], 12'h0};
			p0_s9    <= PRES_FULL - 64'(adcp_s8);
			temp_s9  <= temp_s8;
			// s10: divisor product and dividend pre-term
			ppf_s10  <= mul_pp(PRES_BIAS + w1b_s9, p1);
			nin_s10  <= {p0_s9[32:0], 31'h0} - w2_s9;
			temp_s10 <= temp_s9;
			// s11
			f_s11    <= mul_sum(ppf_s10);
			ppn_s11  <= mul_pp(nin_s10, PRES_SCALE);
			temp_s11 <= temp_s10;
			// s12
			n_s12    <= mul_sum(ppn_s11);
			dv_s12   <= dvfull[DIVISOR_W-1:0];
			temp_s12 <= temp_s11;
			// s13: magnitudes and signs for the divider
			nmag_s13      <= n_s12[63] ? (64'h0 - n_s12) : n_s12;
			dmag_s13      <= dv_s12[DIVISOR_W-1] ? (DIVISOR_W'(0) - dv_s12) : dv_s12;
			side_s13.neg  <= n_s12[63] ^ dv_s12[DIVISOR_W-1];
			side_s13.zero <= dv_s12 == '0;
			side_s13.temp <= temp_s12;
		end
	end

	// quotient, one bit per stage
	logic [63:0] q_div;
	div_side_t   side_div;

	bsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s13),
		.dividend (nmag_s13),
		.divisor  (dmag_s13),
		.side_in  (side_s13),
		.out_vld  (div_vld),
		.quotient (q_div),
		.side_out (side_div)
	);

	// post-divider stages
	logic [63:0] p_s14, p_s15, p_s16, p_s17, p_s18, ps_s15, ps_s16, t_s16;
	logic [63:0] x2_s16, x2_s17, x2_s18, x1_s18, s_s19;
	logic [63:0] ps14, fin19;
	pp_t ppt_s15, ppx2_s15, ppx1_s17;
	logic [31:0] temp_s14, temp_s15, temp_s16, temp_s17, temp_s18, temp_s19, temp_s20;
	logic zero_s14, zero_s15, zero_s16, zero_s17, zero_s18, zero_s19, zero_s20;
	logic [31:0] pres_s20;

	assign ps14  = $signed(p_s14) >>> 13;
	assign fin19 = 64'($signed(s_s19) >>> 8) + {p7[59:0], 4'h0};

	always_ff @(posedge clk) begin
		if (adv) begin
			// s14: signed quotient
			p_s14    <= side_div.neg ? (64'h0 - q_div) : q_div;
			temp_s14 <= side_div.temp;
			zero_s14 <= side_div.zero;
			// s15: p9*ps and p8*p
			ppt_s15  <= mul_pp(p9, ps14);
			ppx2_s15 <= mul_pp(p8, p_s14);
			ps_s15   <= ps14;
			p_s15    <= p_s14;
			temp_s15 <= temp_s14;
			zero_s15 <= zero_s14;
			// s16
			t_s16    <= mul_sum(ppt_s15);
			x2_s16   <= 64'($signed(mul_sum(ppx2_s15)) >>> 19);
			ps_s16   <= ps_s15;
			p_s16    <= p_s15;
			temp_s16 <= temp_s15;
			zero_s16 <= zero_s15;
			// s17: times ps again
			ppx1_s17 <= mul_pp(t_s16, ps_s16);
			x2_s17   <= x2_s16;
			p_s17    <= p_s16;
			temp_s17 <= temp_s16;
			zero_s17 <= zero_s16;
			// s18
			x1_s18   <= 64'($signed(mul_sum(ppx1_s17)) >>> 25);
			x2_s18   <= x2_s17;
			p_s18    <= p_s17;
			temp_s18 <= temp_s17;
			zero_s18 <= zero_s17;
			// s19
			s_s19    <= p_s18 + x1_s18 + x2_s18;
			temp_s19 <= temp_s18;
			zero_s19 <= zero_s18;
			// s20: output word
			pres_s20 <= zero_s19 ? 32'h0 : fin19[31:0];
			temp_s20 <= temp_s19;
			zero_s20 <= zero_s19;
		end
	end

	assign comp.valid             = vld_s20;
	assign comp.temperature_centi = temp_s20;
	assign comp.pressure_q24_8    = pres_s20;
	assign comp.divisor_zero      = zero_s20;

endmodule

>>> rtl/bsc_div.sv
// pipelined unsigned divider, one quotient bit per stage
// 64-bit dividend, 31-bit divisor; depends on bsc_pkg
`timescale 1ns / 1ps

module bsc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_vld,
	input  logic [63:0]                   dividend,
	input  logic [bsc_pkg::DIVISOR_W-1:0] divisor,
	input  bsc_pkg::div_side_t            side_in,
	output logic                          out_vld,
	output logic [63:0]                   quotient,
	output bsc_pkg::div_side_t            side_out
);
	import bsc_pkg::*;

	logic                 vld_s  [DIV_STAGES];
	logic [DIVISOR_W-1:0] rem_s  [DIV_STAGES];
	logic [63:0]          qd_s   [DIV_STAGES];
	logic [DIVISOR_W-1:0] dvs_s  [DIV_STAGES];
	div_side_t            side_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic                 vld_prev;
		logic [DIVISOR_W-1:0] rem_prev;
		logic [63:0]          qd_prev;
		logic [DIVISOR_W-1:0] dvs_prev;
		div_side_t            side_prev;
		logic [DIVISOR_W:0]   sh;
		logic                 ge;
		logic [DIVISOR_W:0]   diff;

		// stage input: from the ports or the previous stage
		if (k == 0) begin : g_first
			assign vld_prev  = in_vld;
			assign rem_prev  = '0;
			assign qd_prev   = dividend;
			assign dvs_prev  = divisor;
			assign side_prev = side_in;
		end else begin : g_next
			assign vld_prev  = vld_s[k-1];
			assign rem_prev  = rem_s[k-1];
			assign qd_prev   = qd_s[k-1];
			assign dvs_prev  = dvs_s[k-1];
			assign side_prev = side_s[k-1];
		end

		// shift in the next dividend bit, trial subtract
		assign sh   = {rem_prev, qd_prev[63]};
		assign ge   = sh >= {1'b0, dvs_prev};
		assign diff = sh - {1'b0, dvs_prev};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[DIVISOR_W-1:0] : sh[DIVISOR_W-1:0];
				qd_s[k]   <= {qd_prev[62:0], ge};
				dvs_s[k]  <= dvs_prev;
				side_s[k] <= side_prev;
			end
		end
	end

	assign out_vld  = vld_s[DIV_STAGES-1];
	assign quotient = qd_s[DIV_STAGES-1];
	assign side_out = side_s[DIV_STAGES-1];

endmodule

>>> rtl/bsc_chk.sv
// port-level checker for the compensation core, bound to the top level
// depends on barometric_sensor_compensation_core_defines.svh
`timescale 1ns / 1ps
`include "barometric_sensor_compensation_core_defines.svh"

module bsc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        raw_valid,
	input logic        raw_ready,
	input logic        comp_valid,
	input logic        comp_ready,
	input logic [31:0] comp_temperature_centi,
	input logic [31:0] comp_pressure_q24_8,
	input logic        comp_divisor_zero
);

	// a stalled output word stays put
	`BSC_AST_NXT(a_comp_hold, comp_valid && !comp_ready, comp_valid && $stable(comp_temperature_centi) && $stable(comp_pressure_q24_8) && $stable(comp_divisor_zero))

	// zero divisor forces the pressure to zero
	`BSC_AST_IMP(a_zero_div, comp_valid && comp_divisor_zero, comp_pressure_q24_8 == 32'h0)

	// input ready is high exactly when the output side can move
	`BSC_AST_IMP(a_ready_flow, raw_valid || !raw_valid, raw_ready == (!comp_valid || comp_ready))

endmodule

bind barometric_sensor_compensation_core bsc_chk u_bsc_chk (
	.clk                    (clk),
	.arst_n                 (arst_n),
	.raw_valid              (raw.valid),
	.raw_ready              (raw.ready),
	.comp_valid             (comp.valid),
	.comp_ready             (comp.ready),
	.comp_temperature_centi (comp.temperature_centi),
	.comp_pressure_q24_8    (comp.pressure_q24_8),
	.comp_divisor_zero      (comp.divisor_zero)
);

>>> tb/sv/bsc_comp_checker.sv
// checker for the compensation core: watches the raw and comp channels and config writes
// predicts every result word and compares in order; depends on bsc_pkg and bsc_ifs
`timescale 1ns / 1ps

module bsc_comp_checker (
	input  logic        clk,
	input  logic        arst_n,
	bsc_raw_if          raw,
	bsc_comp_if         comp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output int          mismatches,
	output int          pending
);
	import bsc_pkg::*;

	typedef struct packed {
		logic [31:0] temperature;
		logic [31:0] pressure;
		logic        div_zero;
	} comp_word_t;

	logic [47:0] temp_cal, pres_cal_a, pres_cal_b, pres_cal_c;
	comp_word_t  expected_words[$];

	function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [63:0] sext16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	// datasheet compensation: 32-bit temperature stage, 64-bit pressure stage
	function automatic comp_word_t compensate(input logic [19:0] adc_t, input logic [19:0] adc_p);
		comp_word_t  r;
		logic [31:0] t1, t2, t3, m, v1, v2, d, fine;
		logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [63:0] w1, w2, p, num, mag_n, mag_d, q, ps, x1, x2;
		t1 = {16'h0, temp_cal[15:0]};
		t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
		t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
		m = ((32'(adc_t) >> 3) - (t1 << 1)) * t2;
		v1 = asr32(m, 11);
		d = (32'(adc_t) >> 4) - t1;
		v2 = asr32(asr32(d * d, 12) * t3, 14);
		fine = v1 + v2;
		r.temperature = asr32(fine * 32'd5 + 32'd128, 8);
		p1 = {48'h0, pres_cal_a[15:0]};
		p2 = sext16(pres_cal_a[31:16]);
		p3 = sext16(pres_cal_a[47:32]);
		p4 = sext16(pres_cal_b[15:0]);
		p5 = sext16(pres_cal_b[31:16]);
		p6 = sext16(pres_cal_b[47:32]);
		p7 = sext16(pres_cal_c[15:0]);
		p8 = sext16(pres_cal_c[31:16]);
		p9 = sext16(pres_cal_c[47:32]);
		w1 = {{32{fine[31]}}, fine} - 64'd128000;
		w2 = w1 * w1 * p6;
		w2 = w2 + ((w1 * p5) << 17);
		w2 = w2 + (p4 << 35);
		w1 = asr64(w1 * w1 * p3, 8) + ((w1 * p2) << 12);
		w1 = asr64(((64'd1 << 47) + w1) * p1, 33);
		r.pressure = '0;
		r.div_zero = (w1 == 64'd0);
		if (!r.div_zero) begin
			p = 64'd1048576 - 64'(adc_p);
			num = ((p << 31) - w2) * 64'd3125;
			// truncating signed divide, built from magnitudes
			mag_n = num[63] ? -num : num;
			mag_d = w1[63] ? -w1 : w1;
			q = mag_n / mag_d;
			p = (num[63] ^ w1[63]) ? -q : q;
			ps = asr64(p, 13);
			x1 = asr64(p9 * ps * ps, 25);
			x2 = asr64(p8 * p, 19);
			p = asr64(p + x1 + x2, 8) + (p7 << 4);
			r.pressure = p[31:0];
		end
		return r;
	endfunction

	// shadow of the calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal   <= '0;
			pres_cal_a <= '0;
			pres_cal_b <= '0;
			pres_cal_c <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (cfg_idx_t'(paddr[4:3]))
				CFG_TEMP:   temp_cal   <= pwdata[47:0];
				CFG_PRES_A: pres_cal_a <= pwdata[47:0];
				CFG_PRES_B: pres_cal_b <= pwdata[47:0];
				CFG_PRES_C: pres_cal_c <= pwdata[47:0];
				default:    ;
			endcase
		end
	end

	// predict on accepted readings, compare on accepted results
	always @(posedge clk) begin
		comp_word_t exp_w;
		if (arst_n) begin
			if (raw.valid && raw.ready)
				expected_words.push_back(compensate(raw.adc_temperature, raw.adc_pressure));
			if (comp.valid && comp.ready) begin
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word: temp %0d pres %h flag %b",
							comp.temperature_centi, comp.pressure_q24_8, comp.divisor_zero);
				end else begin
					exp_w = expected_words.pop_front();
					if (exp_w.temperature !== comp.temperature_centi
						|| exp_w.pressure !== comp.pressure_q24_8
						|| exp_w.div_zero !== comp.divisor_zero) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp temp %0d pres %h flag %b, got %0d %h %b",
								$signed(exp_w.temperature), exp_w.pressure, exp_w.div_zero,
								comp.temperature_centi, comp.pressure_q24_8,
								comp.divisor_zero);
					end
				end
			end
			pending <= expected_words.size();
		end
	end

endmodule

>>> tb/sv/tb.sv
// top of the compensation core testbench: clock, reset, stimulus and verdict
// depends on bsc_pkg, bsc_ifs, the core and bsc_comp_checker
`timescale 1ns / 1ps

module tb;
	import bsc_pkg::*;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	int          mismatches, pending;
	int          send_idle_pct, recv_stall_pct;
	bit          long_stall_req;

	bsc_raw_if  raw_ch();
	bsc_comp_if comp_ch();

	barometric_sensor_compensation_core DUT (
		.clk(clk), .arst_n(arst_n), .raw(raw_ch.sink), .comp(comp_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	bsc_comp_checker checker_i (
		.clk(clk), .arst_n(arst_n), .raw(raw_ch), .comp(comp_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .mismatches(mismatches), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("barometric_sensor_compensation_core test failed");
		$finish;
	end

	// receiver: random stalls plus an occasional long hold-off
	initial begin
		int hold_left;
		hold_left = 0;
		comp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_stall_req) begin
				long_stall_req = 0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				comp_ch.ready <= 1'b0;
			end else begin
				comp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic set_idle(input idle_mode_t mode);
		send_idle_pct  = (mode == IDLE_SEND) ? 78 : (mode == IDLE_BOTH) ? 32 : 0;
		recv_stall_pct = (mode == IDLE_RECV) ? 78 : (mode == IDLE_BOTH) ? 32 : 0;
	endtask

	// offer one reading word and hold it until accepted
	task automatic send_word(input logic [19:0] adc_t, input logic [19:0] adc_p);
		while ($urandom_range(99) < send_idle_pct) begin
			raw_ch.valid <= 1'b0;
			@(posedge clk);
		end
		raw_ch.valid           <= 1'b1;
		raw_ch.adc_temperature <= adc_t;
		raw_ch.adc_pressure    <= adc_p;
		@(posedge clk);
		while (!raw_ch.ready) @(posedge clk);
	endtask

	task automatic drain();
		raw_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic apb_write(input cfg_idx_t idx, input logic [47:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [47:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	initial begin
		logic [47:0] cal[4];
		logic [19:0] adc_t, adc_p;
		arst_n         = 1'b0;
		long_stall_req = 0;
		set_idle(IDLE_NONE);
		raw_ch.valid           <= 1'b0;
		raw_ch.adc_temperature <= '0;
		raw_ch.adc_pressure    <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		repeat (8) @(posedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 8; ph++) begin
			// calibration per phase: reset zeros, typical, all ones, field extremes, random
			if (ph > 0) begin
				case (ph)
					1: cal = '{{-16'sd1000, 16'd26435, 16'd27504},
						{16'd3024, -16'sd10685, 16'd36477},
						{-16'sd7, 16'd140, 16'd2855},
						{16'd6000, -16'sd14600, 16'd15500}};
					2: cal = '{48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
						48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF};
					3: cal = '{48'h7FFF_7FFF_FFFF, 48'h7FFF_7FFF_FFFF,
						48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF};
					4: cal = '{48'h8000_8000_0000, 48'h8000_8000_0001,
						48'h8000_8000_8000, 48'h8000_8000_8000};
					default: cal = '{rand48(), rand48(), rand48(), rand48()};
				endcase
				apb_write(CFG_TEMP, cal[0]);
				apb_write(CFG_PRES_A, cal[1]);
				apb_write(CFG_PRES_B, cal[2]);
				apb_write(CFG_PRES_C, cal[3]);
			end
			set_idle(idle_mode_t'(ph % 4));

			// field extremes and bit patterns
			if (ph == 1 || ph == 2) begin
				send_word(20'h00000, 20'h00000);
				send_word(20'hFFFFF, 20'hFFFFF);
				send_word(20'h00000, 20'hFFFFF);
				send_word(20'hFFFFF, 20'h00000);
				send_word(20'hAAAAA, 20'h55555);
				send_word(20'h55555, 20'hAAAAA);
				send_word(20'd519888, 20'd415148);
				send_word(20'd440000, 20'd300000);
				send_word(20'h80000, 20'h80000);
				send_word(20'h7FFFF, 20'h7FFFF);
			end

			for (int i = 0; i < 200; i++) begin
				// long receiver hold-off while the sender never idles
				if (ph == 4 && i == 20)
					long_stall_req = 1;
				if (ph == 2 && i == 100)
					drain();
				if ($urandom_range(3) == 0) begin
					adc_t = 20'($urandom);
					adc_p = 20'($urandom);
				end else begin
					adc_t = 20'($urandom_range(600000, 380000));
					adc_p = 20'($urandom_range(600000, 200000));
				end
				send_word(adc_t, adc_p);
			end
			drain();
		end

		if (mismatches == 0 && pending == 0) begin
			$display("barometric_sensor_compensation_core test passed");
		end else begin
			$display("barometric_sensor_compensation_core test failed");
		end
		$finish;
	end

endmodule
